// File: hw/rtl/qcco_pkg.sv
// qcco_pkg: widths, payload structs and internal types for the quad corner
// counterclockwise ordering unit. Used by every module under hw/rtl.
package qcco_pkg;

  localparam int COORD_BITS = 20;
  localparam int D_BITS     = COORD_BITS + 3;
  localparam int PROD_BITS  = 2 * D_BITS;
  localparam int TERM_BITS  = 2 * COORD_BITS + 1;
  localparam int AREA_BITS  = 2 * COORD_BITS + 3;
  localparam int THR_BITS   = 40;
  localparam int CMP_BITS   = (AREA_BITS > THR_BITS) ? AREA_BITS : THR_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [D_BITS-1:0]     dvec_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [TERM_BITS-1:0]  term_t;
  typedef logic signed [AREA_BITS-1:0]  area_t;
  typedef logic [THR_BITS-1:0]          thr_t;
  typedef logic [1:0]                   idx_t;

  localparam thr_t THR_RESET = thr_t'(1);

  typedef struct packed {
    coord_t x;
    coord_t y;
  } corner_t;

  typedef corner_t [3:0]     corner_set_t;
  typedef idx_t [3:0]        order_t;
  typedef logic [3:0][3:0]   less_mat_t;   // [i][j]: corner i ranks before corner j
  typedef term_t [3:0][3:0]  term_mat_t;   // [a][b]: doubled area term of edge a->b

  // half-plane class of a centroid vector
  typedef enum logic [1:0] {
    ANG_LOWER = 2'd0,   // angle in (-pi, 0)
    ANG_UPPER = 2'd1,   // angle in [0, pi)
    ANG_NEG_X = 2'd2    // angle pi
  } ang_cls_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    coord_t third_x;
    coord_t third_y;
    coord_t fourth_x;
    coord_t fourth_y;
  } in_item_t;

  typedef struct packed {
    coord_t out0_x;
    coord_t out0_y;
    coord_t out1_x;
    coord_t out1_y;
    coord_t out2_x;
    coord_t out2_y;
    coord_t out3_x;
    coord_t out3_y;
    logic   collinear;
  } out_item_t;

endpackage

// File: hw/rtl/qcco_cross.sv
// qcco_cross: centroid vectors, pairwise angle compares and edge area terms.
// Depends on qcco_pkg.
module qcco_cross (
  input  qcco_pkg::corner_set_t pts,
  output qcco_pkg::less_mat_t   less,
  output qcco_pkg::term_mat_t   term
);

  qcco_pkg::dvec_t    sx, sy;
  qcco_pkg::dvec_t    dx [4];
  qcco_pkg::dvec_t    dy [4];
  qcco_pkg::dvec_t    ax [4];
  qcco_pkg::ang_cls_t cls [4];

  always_comb begin
    sx = qcco_pkg::D_BITS'(pts[0].x) + qcco_pkg::D_BITS'(pts[1].x)
       + qcco_pkg::D_BITS'(pts[2].x) + qcco_pkg::D_BITS'(pts[3].x);
    sy = qcco_pkg::D_BITS'(pts[0].y) + qcco_pkg::D_BITS'(pts[1].y)
       + qcco_pkg::D_BITS'(pts[2].y) + qcco_pkg::D_BITS'(pts[3].y);
    for (int i = 0; i < 4; i++) begin
      dx[i] = (qcco_pkg::D_BITS'(pts[i].x) <<< 2) - sx;
      dy[i] = (qcco_pkg::D_BITS'(pts[i].y) <<< 2) - sy;
      // a corner on the centroid ranks like the +x direction
      ax[i] = (dx[i] == '0 && dy[i] == '0) ? qcco_pkg::dvec_t'(1) : dx[i];
      if (dy[i] < 0) begin
        cls[i] = qcco_pkg::ANG_LOWER;
      end else if (dy[i] > 0 || dx[i] >= 0) begin
        cls[i] = qcco_pkg::ANG_UPPER;
      end else begin
        cls[i] = qcco_pkg::ANG_NEG_X;
      end
    end
  end

  always_comb begin
    qcco_pkg::prod_t  cl, cr;
    qcco_pkg::coord_t pa, pb;
    logic             same;
    less = '0;
    term = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (i < j) begin
          cl   = ax[i] * dy[j];
          cr   = dy[i] * ax[j];
          same = (cls[i] == cls[j]) && (cls[i] != qcco_pkg::ANG_NEG_X);
          less[i][j] = (cls[i] < cls[j]) || (same && (cl > cr));
          less[j][i] = (cls[j] < cls[i]) || (same && (cr > cl));
          pa = pts[i].x;
          pb = pts[j].y;
          term[i][j] = qcco_pkg::term_t'(pa) * qcco_pkg::term_t'(pb)
                     - qcco_pkg::term_t'(pts[i].y) * qcco_pkg::term_t'(pts[j].x);
          term[j][i] = -term[i][j];
        end
      end
    end
  end

endmodule

// File: hw/rtl/qcco_order.sv
// qcco_order: stable rank of the four corners and the doubled signed area
// of the sorted order. Depends on qcco_pkg.
module qcco_order (
  input  qcco_pkg::less_mat_t less,
  input  qcco_pkg::term_mat_t term,
  output qcco_pkg::order_t    ord,
  output qcco_pkg::area_t     area
);

  qcco_pkg::idx_t rank [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 4; j++) begin
        // earlier input wins ties
        if (j != i && (less[j][i] || (j < i && !less[i][j] && !less[j][i]))) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    ord = '0;
    for (int i = 0; i < 4; i++) begin
      ord[rank[i]] = qcco_pkg::idx_t'(i);
    end
  end

  always_comb begin
    area = '0;
    for (int r = 0; r < 4; r++) begin
      area = area + qcco_pkg::AREA_BITS'(
        qcco_pkg::term_t'(term[ord[r]][ord[qcco_pkg::idx_t'(r + 1)]]));
    end
  end

endmodule

// File: hw/rtl/qcco_select.sv
// qcco_select: collinear test on the area magnitude and final corner mux.
// Depends on qcco_pkg.
module qcco_select (
  input  qcco_pkg::corner_set_t pts,
  input  qcco_pkg::order_t      ord,
  input  qcco_pkg::area_t       area,
  input  qcco_pkg::thr_t        thr,
  output qcco_pkg::out_item_t   item
);

  logic                           neg;
  logic [qcco_pkg::AREA_BITS-1:0] mag;
  logic                           collinear;
  qcco_pkg::corner_set_t          sel;

  always_comb begin
    neg       = area[qcco_pkg::AREA_BITS-1];
    mag       = neg ? (-area) : area;
    collinear = qcco_pkg::CMP_BITS'(mag) < qcco_pkg::CMP_BITS'(thr);
    for (int i = 0; i < 4; i++) begin
      if (collinear) begin
        sel[i] = pts[i];
      end else if (neg) begin
        sel[i] = pts[ord[3-i]];
      end else begin
        sel[i] = pts[ord[i]];
      end
    end
    item.out0_x    = sel[0].x;
    item.out0_y    = sel[0].y;
    item.out1_x    = sel[1].x;
    item.out1_y    = sel[1].y;
    item.out2_x    = sel[2].x;
    item.out2_y    = sel[2].y;
    item.out3_x    = sel[3].x;
    item.out3_y    = sel[3].y;
    item.collinear = collinear;
  end

endmodule

// File: hw/rtl/quad_corner_ccw_order_unit.sv
// quad_corner_ccw_order_unit: orders four corners counterclockwise.
// Accepts one beat per cycle while out_ready does not stall the result side.
// Four register stages (input, compares/products, order/area, result) set
// the latency; the multipliers of the compare stage set the clock.
// Reset clears all stage valids; the threshold thr_r resets to 1.
// Depends on qcco_pkg, qcco_cross, qcco_order, qcco_select.
module quad_corner_ccw_order_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  qcco_pkg::thr_t      cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  qcco_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output qcco_pkg::out_item_t out_item
);

  qcco_pkg::thr_t        thr_r;

  logic                  s1_v_r;
  qcco_pkg::in_item_t    s1_item_r;
  qcco_pkg::corner_set_t s1_pts;

  logic                  s2_v_r;
  qcco_pkg::corner_set_t s2_pts_r;
  qcco_pkg::less_mat_t   s2_less_r, s2_less_nxt;
  qcco_pkg::term_mat_t   s2_term_r, s2_term_nxt;

  logic                  s3_v_r;
  qcco_pkg::corner_set_t s3_pts_r;
  qcco_pkg::order_t      s3_ord_r, s3_ord_nxt;
  qcco_pkg::area_t       s3_area_r, s3_area_nxt;

  logic                  out_valid_r;
  qcco_pkg::out_item_t   out_item_r, out_item_nxt;

  logic out_free, s3_free, s2_free, s1_free;

  assign out_free  = !out_valid_r || out_ready;
  assign s3_free   = !s3_v_r || out_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_ready  = s1_free;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    s1_pts[0].x = s1_item_r.first_x;
    s1_pts[0].y = s1_item_r.first_y;
    s1_pts[1].x = s1_item_r.second_x;
    s1_pts[1].y = s1_item_r.second_y;
    s1_pts[2].x = s1_item_r.third_x;
    s1_pts[2].y = s1_item_r.third_y;
    s1_pts[3].x = s1_item_r.fourth_x;
    s1_pts[3].y = s1_item_r.fourth_y;
  end

  qcco_cross u_cross (
    .pts  (s1_pts),
    .less (s2_less_nxt),
    .term (s2_term_nxt)
  );

  qcco_order u_order (
    .less (s2_less_r),
    .term (s2_term_r),
    .ord  (s3_ord_nxt),
    .area (s3_area_nxt)
  );

  qcco_select u_select (
    .pts  (s3_pts_r),
    .ord  (s3_ord_r),
    .area (s3_area_r),
    .thr  (thr_r),
    .item (out_item_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= qcco_pkg::THR_RESET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (s1_free) begin
        s1_v_r <= in_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (out_free) begin
        out_valid_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_item_r <= in_item;
    end
    if (s2_free && s1_v_r) begin
      s2_pts_r  <= s1_pts;
      s2_less_r <= s2_less_nxt;
      s2_term_r <= s2_term_nxt;
    end
    if (s3_free && s2_v_r) begin
      s3_pts_r  <= s2_pts_r;
      s3_ord_r  <= s3_ord_nxt;
      s3_area_r <= s3_area_nxt;
    end
    if (out_free && s3_v_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // downstream ready must never stall the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side ready");

  // the stable rank must be a permutation
  a_perm: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (s3_ord_r[0] != s3_ord_r[1] && s3_ord_r[0] != s3_ord_r[2] &&
                s3_ord_r[0] != s3_ord_r[3] && s3_ord_r[1] != s3_ord_r[2] &&
                s3_ord_r[1] != s3_ord_r[3] && s3_ord_r[2] != s3_ord_r[3]))
    else $error("corner order is not a permutation");

  // a finished item moves to the result register when it is free
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && out_free) |=> out_valid_r)
    else $error("finished item lost before result register");

endmodule

// File: tb/tb_quad_corner_ccw_order_unit.sv
// tb_quad_corner_ccw_order_unit: self-checking bench for the ccw corner ordering unit.
// Directed corner sets, then random ones under bursty input and stalling output, checked
// by a behavioral ordering model. Depends on qcco_pkg and quad_corner_ccw_order_unit.
module tb_quad_corner_ccw_order_unit;

  localparam int CMIN = -524288;
  localparam int CMAX = 524287;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_QUADS = 200;
  localparam int HOLD_AFTER = 500;
  localparam int HOLD_CYCLES = 300;
  localparam qcco_pkg::thr_t THR_MAX = '1;

  typedef struct {
    bit                  set_thr;
    qcco_pkg::thr_t      thr;
    qcco_pkg::in_item_t  quad;
    bit                  typed;
    qcco_pkg::out_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  qcco_pkg::thr_t      cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  qcco_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  qcco_pkg::out_item_t out_item;

  qcco_pkg::out_item_t pending_orders[$];
  qcco_pkg::out_item_t got_want;
  dir_row_t            plan[$];
  qcco_pkg::thr_t      thr_now;
  qcco_pkg::thr_t      phase_thr[6];
  bit                  cur_typed;
  qcco_pkg::out_item_t cur_want;
  bit                  long_hold_done = 1'b0;
  int                  mismatches = 0;
  int                  in_beats = 0;
  int                  burst_left = 0;
  int                  cycles = 0;
  int                  rx_mode = 0;
  int                  rx_tick = 0;

  quad_corner_ccw_order_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic qcco_pkg::ang_cls_t half_plane(longint x, longint y);
    if (y < 0) return qcco_pkg::ANG_LOWER;
    if (y > 0 || x >= 0) return qcco_pkg::ANG_UPPER;
    return qcco_pkg::ANG_NEG_X;
  endfunction

  function automatic bit ranks_before(longint ax, longint ay, longint bx, longint by);
    qcco_pkg::ang_cls_t ca;
    qcco_pkg::ang_cls_t cb;
    longint             cr;
    ca = half_plane(ax, ay);
    cb = half_plane(bx, by);
    if (ca != cb) return ca < cb;
    if (ca == qcco_pkg::ANG_NEG_X) return 1'b0;
    if (ax == 0 && ay == 0) ax = 1;
    if (bx == 0 && by == 0) bx = 1;
    cr = ax * by - ay * bx;
    return cr > 0;
  endfunction

  function automatic qcco_pkg::out_item_t ccw_order(qcco_pkg::in_item_t q,
                                                    qcco_pkg::thr_t thr);
    longint              px[4];
    longint              py[4];
    longint              dx[4];
    longint              dy[4];
    longint              sx;
    longint              sy;
    longint              area;
    longint              mag;
    longint              lim;
    int                  ord[4];
    int                  pick[4];
    int                  j;
    int                  tmp;
    bit                  col;
    qcco_pkg::out_item_t r;
    px[0] = q.first_x;  py[0] = q.first_y;
    px[1] = q.second_x; py[1] = q.second_y;
    px[2] = q.third_x;  py[2] = q.third_y;
    px[3] = q.fourth_x; py[3] = q.fourth_y;
    sx = 0;
    sy = 0;
    for (int i = 0; i < 4; i++) begin
      sx += px[i];
      sy += py[i];
      ord[i] = i;
    end
    for (int i = 0; i < 4; i++) begin
      dx[i] = 4 * px[i] - sx;
      dy[i] = 4 * py[i] - sy;
    end
    // stable insertion sort by angle about the centroid
    for (int i = 1; i < 4; i++) begin
      j = i;
      while (j > 0 && ranks_before(dx[ord[j]], dy[ord[j]], dx[ord[j-1]], dy[ord[j-1]])) begin
        tmp = ord[j];
        ord[j] = ord[j-1];
        ord[j-1] = tmp;
        j--;
      end
    end
    area = 0;
    for (int i = 0; i < 4; i++)
      area += px[ord[i]] * py[ord[(i+1)%4]] - py[ord[i]] * px[ord[(i+1)%4]];
    mag = (area < 0) ? -area : area;
    lim = thr;
    col = mag < lim;
    for (int i = 0; i < 4; i++)
      pick[i] = col ? i : ((area < 0) ? ord[3-i] : ord[i]);
    r.out0_x = qcco_pkg::coord_t'(px[pick[0]]); r.out0_y = qcco_pkg::coord_t'(py[pick[0]]);
    r.out1_x = qcco_pkg::coord_t'(px[pick[1]]); r.out1_y = qcco_pkg::coord_t'(py[pick[1]]);
    r.out2_x = qcco_pkg::coord_t'(px[pick[2]]); r.out2_y = qcco_pkg::coord_t'(py[pick[2]]);
    r.out3_x = qcco_pkg::coord_t'(px[pick[3]]); r.out3_y = qcco_pkg::coord_t'(py[pick[3]]);
    r.collinear = col;
    return r;
  endfunction

  function automatic qcco_pkg::in_item_t quad(int x0, int y0, int x1, int y1,
                                              int x2, int y2, int x3, int y3);
    qcco_pkg::in_item_t q;
    q.first_x  = qcco_pkg::coord_t'(x0); q.first_y  = qcco_pkg::coord_t'(y0);
    q.second_x = qcco_pkg::coord_t'(x1); q.second_y = qcco_pkg::coord_t'(y1);
    q.third_x  = qcco_pkg::coord_t'(x2); q.third_y  = qcco_pkg::coord_t'(y2);
    q.fourth_x = qcco_pkg::coord_t'(x3); q.fourth_y = qcco_pkg::coord_t'(y3);
    return q;
  endfunction

  function automatic int pm(int span);
    int v;
    v = $urandom_range(0, 2 * span);
    return v - span;
  endfunction

  function automatic qcco_pkg::in_item_t random_quad();
    int xs[4];
    int ys[4];
    int picks[5];
    int kind;
    int cx;
    int cy;
    int r;
    int jit;
    int k;
    int t;
    picks = '{CMIN, CMAX, 0, -1, 1};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        for (int i = 0; i < 4; i++) begin
          xs[i] = $urandom();
          ys[i] = $urandom();
        end
      end
      2, 3, 4: begin
        cx = pm(200000);
        cy = pm(200000);
        r = $urandom_range(1, 250000);
        jit = r / 8;
        xs[0] = cx + r;        ys[0] = cy + pm(jit);
        xs[1] = cx + pm(jit);  ys[1] = cy + r;
        xs[2] = cx - r;        ys[2] = cy + pm(jit);
        xs[3] = cx + pm(jit);  ys[3] = cy - r;
      end
      5: begin
        for (int i = 0; i < 4; i++) begin
          xs[i] = pm(4);
          ys[i] = pm(4);
        end
      end
      6: begin
        cx = pm(1000);
        cy = pm(1000);
        r = pm(50);
        jit = pm(50);
        for (int i = 0; i < 4; i++) begin
          k = pm(20);
          xs[i] = cx + k * r;
          ys[i] = cy + k * jit;
        end
      end
      7: begin
        for (int i = 0; i < 4; i++) begin
          xs[i] = pm(1000);
          ys[i] = pm(1000);
        end
        for (int n = 0; n < 2; n++) begin
          k = $urandom_range(0, 3);
          t = $urandom_range(0, 3);
          xs[t] = xs[k];
          ys[t] = ys[k];
        end
      end
      8: begin
        for (int i = 0; i < 4; i++) begin
          xs[i] = picks[$urandom_range(0, 4)];
          ys[i] = picks[$urandom_range(0, 4)];
        end
      end
      default: begin
        // one corner sits on the centroid
        for (int i = 1; i < 4; i++) begin
          xs[i] = pm(100000);
          ys[i] = pm(100000);
        end
        xs[0] = 3 * xs[3] - xs[1] - xs[2];
        ys[0] = 3 * ys[3] - ys[1] - ys[2];
      end
    endcase
    for (int i = 3; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = xs[i]; xs[i] = xs[k]; xs[k] = t;
      t = ys[i]; ys[i] = ys[k]; ys[k] = t;
    end
    return quad(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
  endfunction

  task automatic add_row(bit set_thr, qcco_pkg::thr_t thr, qcco_pkg::in_item_t q,
                         bit typed, bit col);
    dir_row_t r;
    r.set_thr = set_thr;
    r.thr = thr;
    r.quad = q;
    r.typed = typed;
    r.want = {q, col};
    plan.insert(plan.size(), r);
  endtask

  task automatic check_coord(string name, qcco_pkg::coord_t want, qcco_pkg::coord_t got);
    if (got !== want) begin
      $display("%0t %s: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_quad(qcco_pkg::in_item_t q, bit typed, qcco_pkg::out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= q;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic set_threshold(qcco_pkg::thr_t v);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thr_now = v;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_orders.insert(pending_orders.size(),
                              cur_typed ? cur_want : ccw_order(in_item, thr_now));
        in_beats++;
      end
      if (out_valid && out_ready) begin
        if (pending_orders.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %p", $time, out_item);
          mismatches++;
        end else begin
          got_want = pending_orders.pop_front();
          check_coord("out0_x", got_want.out0_x, out_item.out0_x);
          check_coord("out0_y", got_want.out0_y, out_item.out0_y);
          check_coord("out1_x", got_want.out1_x, out_item.out1_x);
          check_coord("out1_y", got_want.out1_y, out_item.out1_y);
          check_coord("out2_x", got_want.out2_x, out_item.out2_x);
          check_coord("out2_y", got_want.out2_y, out_item.out2_y);
          check_coord("out3_x", got_want.out3_x, out_item.out3_x);
          check_coord("out3_y", got_want.out3_y, out_item.out3_y);
          check_coord("collinear", qcco_pkg::coord_t'(got_want.collinear),
                      qcco_pkg::coord_t'(out_item.collinear));
        end
      end
    end
  end

  // output side stalls; one long hold-off lets the pipe back up into the input
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && in_beats >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= (rx_tick % 4 != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        rx_tick++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    cur_typed = 1'b0;
    cur_want = '0;
    thr_now = qcco_pkg::THR_RESET;

    add_row(0, '0, quad(0, 0, 0, 0, 0, 0, 0, 0), 1, 1);
    add_row(0, '0, quad(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1, 1);
    add_row(0, '0, quad(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1, 1);
    add_row(0, '0, quad(0, 0, 1, 1, 2, 2, 3, 3), 1, 1);
    add_row(0, '0, quad(0, 0, 10, 0, 10, 10, 0, 10), 1, 0);
    add_row(0, '0, quad(0, 10, 10, 10, 10, 0, 0, 0), 0, 0);
    add_row(0, '0, quad(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN), 0, 0);
    add_row(0, '0, quad(CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN), 0, 0);
    add_row(0, '0, quad(0, 0, 4, 1, -2, 3, -2, -4), 0, 0);
    add_row(0, '0, quad(-4, 0, 2, 3, 2, -3, 0, 0), 0, 0);
    add_row(0, '0, quad(2, 2, 4, 4, -6, 0, 0, -6), 0, 0);
    add_row(0, '0, quad(349525, -349526, -349526, 349525,
                        349525, 349525, -349526, -349526), 0, 0);
    add_row(0, '0, quad(-1, -1, 1, -1, 1, 1, -1, 1), 0, 0);
    add_row(1, '0, quad(0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
    add_row(0, '0, quad(0, 0, 1, 1, 2, 2, 3, 3), 0, 0);
    add_row(0, '0, quad(3, 3, 0, 0, 2, 2, 1, 1), 0, 0);
    add_row(1, THR_MAX, quad(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN), 0, 0);
    add_row(0, '0, quad(0, 0, 10, 0, 10, 10, 0, 10), 1, 1);
    add_row(1, qcco_pkg::thr_t'(200), quad(0, 0, 10, 0, 10, 10, 0, 10), 1, 0);
    add_row(1, qcco_pkg::thr_t'(201), quad(0, 0, 10, 0, 10, 10, 0, 10), 1, 1);

    phase_thr[0] = qcco_pkg::THR_RESET;
    phase_thr[1] = '0;
    phase_thr[2] = qcco_pkg::thr_t'({$urandom(), $urandom()});
    phase_thr[3] = THR_MAX;
    phase_thr[4] = qcco_pkg::thr_t'($urandom_range(0, 5000));
    phase_thr[5] = qcco_pkg::thr_t'({$urandom(), $urandom()}) >> $urandom_range(0, 40);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].set_thr) set_threshold(plan[i].thr);
      send_quad(plan[i].quad, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      set_threshold(phase_thr[p]);
      repeat (PHASE_QUADS) send_quad(random_quad(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
